// File: sv/ots_pkg.sv
// ----------------------------------------------------------------------------
// Oscillator tune search package
// Shared types, register indexes and reset values for the tune search core.
// ----------------------------------------------------------------------------
package ots_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MS_W       = 10;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned SETTLE_W   = 8;
    localparam int unsigned TUNE_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_LIMIT   = 2'd3;

    localparam logic [COUNT_W-1:0]  RST_TARGET_COUNT = 16'd3125;
    localparam logic [MS_W-1:0]     RST_WINDOW_MS    = 10'd100;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_MS    = 8'd2;
    localparam logic [COUNT_W-1:0]  RST_SPEC_LIMIT   = 16'd109;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_MEASURE,
        PH_FINAL
    } t_phase;

    typedef struct packed {
        logic [COUNT_W-1:0]  spec_limit;
        logic [SETTLE_W-1:0] settle_ms;
        logic [MS_W-1:0]     window_ms;
        logic [COUNT_W-1:0]  target_count;
    } t_cfg;

    // Declared from the highest field down so tune_drive lands in bit 0.
    typedef struct packed {
        logic                in_spec;
        logic [COUNT_W-1:0]  best_error;
        logic [TUNE_W-1:0]   best_setting;
        logic                done_res;
        logic                busy_res;
        logic                show_oscillator;
        logic [TUNE_W-1:0]   tune_drive;
    } t_result;

endpackage

// File: sv/ots_cfg_regs.sv
// ----------------------------------------------------------------------------
// Oscillator tune search configuration registers
// Holds target count, window length, settle time and spec limit.
// ----------------------------------------------------------------------------
module ots_cfg_regs
    import ots_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_COUNT: n_cfg.target_count = i_cfg_data;
                CFG_WINDOW_MS:    n_cfg.window_ms    = i_cfg_data[MS_W-1:0];
                CFG_SETTLE_MS:    n_cfg.settle_ms    = i_cfg_data[SETTLE_W-1:0];
                CFG_SPEC_LIMIT:   n_cfg.spec_limit   = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_count <= RST_TARGET_COUNT;
            r_cfg.window_ms    <= RST_WINDOW_MS;
            r_cfg.settle_ms    <= RST_SETTLE_MS;
            r_cfg.spec_limit   <= RST_SPEC_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/ots_engine.sv
// ----------------------------------------------------------------------------
// Oscillator tune search engine
// Sweep state machine, edge counter and best-setting tracker, one sample per beat.
// ----------------------------------------------------------------------------
module ots_engine
    import ots_pkg::*;
#(
    parameter int unsigned TUNE_STEPS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_start,
    input  logic    i_pin,
    input  logic    i_tick,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int unsigned IDX_W = $clog2(TUNE_STEPS);
    localparam int unsigned EXT_W = (IDX_W > TUNE_W) ? IDX_W : TUNE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TUNE_STEPS - 1);

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_trial, n_trial;
    logic [MS_W-1:0]    r_ms, n_ms;
    logic [COUNT_W-1:0] r_edges, n_edges;
    logic               r_prev, n_prev;
    logic               r_primed, n_primed;
    logic [COUNT_W:0]   r_best_err, n_best_err;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;

    logic [MS_W-1:0]    settle_ms_inc;
    logic               settle_done;
    logic [MS_W-1:0]    win;
    logic               win_end;
    logic [COUNT_W-1:0] diff;
    logic               better;
    logic               sweep_done;
    logic [EXT_W-1:0]   drive_ext;
    logic [EXT_W-1:0]   best_ext;

    always_comb begin
        settle_ms_inc = (i_tick && (r_ms != '1)) ? r_ms + 1'b1 : r_ms;
        settle_done   = settle_ms_inc >= MS_W'(i_cfg.settle_ms);
        win           = (i_cfg.window_ms == '0) ? MS_W'(1) : i_cfg.window_ms;
        win_end       = i_tick && (({1'b0, r_ms} + 1'b1) >= {1'b0, win});
        diff          = (i_cfg.target_count >= r_edges) ? i_cfg.target_count - r_edges
                                                        : r_edges - i_cfg.target_count;
        better        = {1'b0, diff} < r_best_err;
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (settle_done) begin
                    n_phase = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (win_end) begin
                    n_phase = (r_trial == LAST_IDX) ? PH_FINAL : PH_SETTLE;
                end
            end
            PH_FINAL: begin
                if (settle_done) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Counters and search registers.
    always_comb begin
        n_trial     = r_trial;
        n_ms        = r_ms;
        n_edges     = r_edges;
        n_prev      = r_prev;
        n_primed    = r_primed;
        n_best_err  = r_best_err;
        n_best_idx  = r_best_idx;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_trial     = '0;
                    n_ms        = '0;
                    n_edges     = '0;
                    n_prev      = 1'b0;
                    n_primed    = 1'b0;
                    n_best_err  = '1;
                    n_best_idx  = '0;
                end
            end
            PH_SETTLE: begin
                n_ms = settle_ms_inc;
                if (settle_done) begin
                    n_ms     = '0;
                    n_edges  = '0;
                    n_primed = 1'b0;
                end
            end
            PH_MEASURE: begin
                if (win_end) begin
                    if (better) begin
                        n_best_err  = {1'b0, diff};
                        n_best_idx  = r_trial;
                    end
                    n_ms = '0;
                    if (r_trial != LAST_IDX) begin
                        n_trial = r_trial + 1'b1;
                    end
                end else begin
                    if (i_tick) begin
                        n_ms = r_ms + 1'b1;
                    end
                    if (!r_primed) begin
                        n_primed = 1'b1;
                    end else if (i_pin && !r_prev && (r_edges != '1)) begin
                        n_edges = r_edges + 1'b1;
                    end
                    n_prev = i_pin;
                end
            end
            PH_FINAL: begin
                n_ms = settle_ms_inc;
            end
            default: begin
                n_ms = r_ms;
            end
        endcase
    end

    // Result fields from the state after this beat.
    always_comb begin
        sweep_done = (r_phase == PH_FINAL) && settle_done;
        drive_ext  = ((n_phase == PH_SETTLE) || (n_phase == PH_MEASURE))
                     ? EXT_W'(n_trial) : EXT_W'(n_best_idx);
        best_ext   = EXT_W'(n_best_idx);
        o_res.tune_drive      = drive_ext[TUNE_W-1:0];
        o_res.show_oscillator = n_phase != PH_IDLE;
        o_res.busy_res        = n_phase != PH_IDLE;
        o_res.done_res        = sweep_done;
        o_res.best_setting    = best_ext[TUNE_W-1:0];
        o_res.best_error      = n_best_err[COUNT_W] ? '1 : n_best_err[COUNT_W-1:0];
        o_res.in_spec         = n_best_err <= {1'b0, i_cfg.spec_limit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_trial     <= '0;
            r_ms        <= '0;
            r_edges     <= '0;
            r_prev      <= 1'b0;
            r_primed    <= 1'b0;
            r_best_err  <= '1;
            r_best_idx  <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_trial     <= n_trial;
            r_ms        <= n_ms;
            r_edges     <= n_edges;
            r_prev      <= n_prev;
            r_primed    <= n_primed;
            r_best_err  <= n_best_err;
            r_best_idx  <= n_best_idx;
        end
    end

endmodule

// File: sv/oscillator_tune_search_core.sv
// ----------------------------------------------------------------------------
// Oscillator tune search core
// Sweeps all tune settings, counts pin edges per window and keeps the best.
// ----------------------------------------------------------------------------
// Each input beat carries one pin sample, a millisecond tick and a start
// request; every input beat yields exactly one output beat with the tune to
// drive, the busy, done and display flags, and the best setting and error.
// An accepted beat waits in the input register, then the engine updates its
// state and writes the output register, where its result is held until the
// receiver takes it. One beat is taken every cycle while the receiver does
// not stall the output; the engine makes one state update for each beat.
// When the receiver stalls, the output register holds its beat and the
// input register still takes one more beat before the input side stalls.
// Configuration writes land in the register file at once and must be made
// while no beat waits in either register; a write during a sweep applies
// from the next beat on. Reset empties both beat registers, loads the
// default configuration and returns the sweep to idle with no best setting.
// ----------------------------------------------------------------------------
module oscillator_tune_search_core
    import ots_pkg::*;
#(
    parameter int unsigned TUNE_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_req [0], pin_level [1], ms_tick [2], zero [7:3]
    input  logic [7:0]            s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tune_drive [3:0], show_oscillator [4], busy_res [5], done_res [6],
    // best_setting [10:7], best_error [26:11], in_spec [27], zero [31:28]
    output logic [31:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_result    res;
    logic       advance;

    logic       r_in_valid;
    logic [2:0] r_in_beat;
    logic       r_out_valid;
    t_result    r_out;

    ots_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ots_engine #(
        .TUNE_STEPS (TUNE_STEPS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_start (r_in_beat[0]),
        .i_pin   (r_in_beat[1]),
        .i_tick  (r_in_beat[2]),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_beat <= s_axis_tdata[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res && !r_out.show_oscillator)
        else $error("done beat still marked busy");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input side stalled with room in the pipeline");

    a_beat_follows_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_axis_tvalid)
        else $error("engine step produced no output beat");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

endmodule
